// File: hw/rtl/fbba_pkg.sv
// Shared types and constants of the frame transient bump allocator.
// Used by the top, controller and datapath modules in hw/rtl; depends on nothing else.
package fbba_pkg;

  localparam int SLOTS_PER_TYPE_DEF = 16;
  localparam int TYPE_COUNT_DEF     = 2;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  STALE_AGE_RST  = 8'd8;
  localparam logic [31:0] MIN_TARGET_RST = 32'h0010_0000;
  localparam logic [31:0] MAX_TARGET_RST = 32'h0400_0000;
  localparam logic [4:0]  STEP_LOG2_RST  = 5'd20;

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_TICK_BEGIN = 2'd1,
    CMD_TICK_END   = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_GRANT = 3'd0,
    EV_EMPTY = 3'd1,
    EV_FREED = 3'd2,
    EV_DONE  = 3'd3,
    EV_FULL  = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    CFG_STALE_AGE  = 2'd0,
    CFG_MIN_TARGET = 2'd1,
    CFG_MAX_TARGET = 2'd2,
    CFG_STEP_LOG2  = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_E_EMPTY, ST_E_FULL, ST_E_DONE, ST_TICK_END,
    ST_A_HEAD, ST_A_SLOT, ST_A_LAT, ST_A_CHK, ST_A_FIND, ST_A_OPEN,
    ST_G_CALC, ST_G_EMIT,
    ST_F_INIT, ST_F_HEAD, ST_F_SLOT, ST_F_LAT, ST_F_DEC,
    ST_U_INIT, ST_U_HEAD, ST_U_SLOT, ST_U_LAT, ST_U_DEC, ST_TB_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_EMPTY, OP_FULL, OP_DONE, OP_TICK_END, OP_TB_START,
    OP_QRD_FREE, OP_QRD_USED, OP_SRD, OP_SLAT, OP_MISS, OP_FIND, OP_OPEN,
    OP_GCALC, OP_GRANT, OP_FINIT, OP_FDEC, OP_UINIT, OP_UDEC, OP_NEXT_TYPE,
    OP_TB_DONE
  } op_t;

  typedef struct packed {
    cmd_t cmd;
    logic size_zero;
    logic type_bad;
    logic free_empty;
    logic rem_zero;
    logic top_fits;
    logic idle_found;
    logic f_release;
    logic u_held;
    logic u_stale;
    logic type_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/frame_transient_bump_allocator_top.sv
// Frame transient bump allocator: per-type slot pools with top-down bump grants.
// An allocate walks the free list from its head, moving each exhausted slot to the used
// list, opens an idle slot when the free list runs empty and reports full when none is
// idle; tick begin walks the free and then the used list of every type.
// One request at a time, taken the cycle after its result is loaded; a stalled output holds it back.
// Synchronous active-high reset empties all lists and clears averages; no clearing pass.
module frame_transient_bump_allocator_top #(
  parameter int SLOTS_PER_TYPE = fbba_pkg::SLOTS_PER_TYPE_DEF,
  parameter int TYPE_COUNT     = fbba_pkg::TYPE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fbba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbba_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // request size, alignment log2, finished tick, starting tick, zero fill
  input  logic [fbba_pkg::IN_DATA_W-1:0]    s_tdata,
  // command, buffer_type
  input  logic [fbba_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot, offset, granted_size, created_size, zero fill
  output logic [fbba_pkg::OUT_DATA_W-1:0]   m_tdata,
  // event_res
  output logic [fbba_pkg::OUT_USER_W-1:0]   m_tuser,
  output logic                              m_tlast
);

  fbba_pkg::op_t        op;
  fbba_pkg::dp_status_t status;

  fbba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .status(status), .op(op)
  );

  fbba_datapath #(
    .SLOTS_PER_TYPE(SLOTS_PER_TYPE), .TYPE_COUNT(TYPE_COUNT)
  ) u_datapath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .op(op), .status(status),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in work");

  a_freed_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == 3'(fbba_pkg::EV_FREED)) |-> !m_tlast)
    else $error("freed-slot result marked last");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == 3'(fbba_pkg::EV_GRANT) || m_tuser == 3'(fbba_pkg::EV_EMPTY)
     || m_tuser == 3'(fbba_pkg::EV_FULL))) |-> m_tlast)
    else $error("single-result event not marked last");

endmodule

// File: hw/rtl/fbba_ram.sv
// Generic single write port RAM with one registered read port.
// Standalone; used by fbba_datapath for the slot table and the slot lists.
module fbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/fbba_ctrl.sv
// Controller state machine of the bump allocator: sequences allocate walks,
// tick begin sweeps and result emission. Depends on fbba_pkg.
module fbba_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  fbba_pkg::dp_status_t   status,
  output fbba_pkg::op_t          op
);

  fbba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = fbba_pkg::OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      fbba_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op         = fbba_pkg::OP_LATCH;
          state_next = fbba_pkg::ST_DECODE;
        end
      end
      fbba_pkg::ST_DECODE: begin
        unique case (status.cmd)
          fbba_pkg::CMD_ALLOC: begin
            if (status.size_zero) begin
              state_next = fbba_pkg::ST_E_EMPTY;
            end else if (status.type_bad) begin
              state_next = fbba_pkg::ST_E_FULL;
            end else begin
              state_next = fbba_pkg::ST_A_HEAD;
            end
          end
          fbba_pkg::CMD_TICK_BEGIN: begin
            op         = fbba_pkg::OP_TB_START;
            state_next = fbba_pkg::ST_F_INIT;
          end
          fbba_pkg::CMD_TICK_END: state_next = fbba_pkg::ST_TICK_END;
          fbba_pkg::CMD_NOP:      state_next = fbba_pkg::ST_E_DONE;
        endcase
      end
      fbba_pkg::ST_E_EMPTY: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_EMPTY;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      fbba_pkg::ST_E_FULL: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_FULL;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      fbba_pkg::ST_E_DONE: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_DONE;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      fbba_pkg::ST_TICK_END: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_TICK_END;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      fbba_pkg::ST_A_HEAD: begin
        if (status.free_empty) begin
          state_next = fbba_pkg::ST_A_FIND;
        end else begin
          op         = fbba_pkg::OP_QRD_FREE;
          state_next = fbba_pkg::ST_A_SLOT;
        end
      end
      fbba_pkg::ST_A_SLOT: begin
        op         = fbba_pkg::OP_SRD;
        state_next = fbba_pkg::ST_A_LAT;
      end
      fbba_pkg::ST_A_LAT: begin
        op         = fbba_pkg::OP_SLAT;
        state_next = fbba_pkg::ST_A_CHK;
      end
      fbba_pkg::ST_A_CHK: begin
        if (status.top_fits) begin
          state_next = fbba_pkg::ST_G_CALC;
        end else begin
          op         = fbba_pkg::OP_MISS;
          state_next = fbba_pkg::ST_A_HEAD;
        end
      end
      fbba_pkg::ST_A_FIND: begin
        if (status.idle_found) begin
          op         = fbba_pkg::OP_FIND;
          state_next = fbba_pkg::ST_A_OPEN;
        end else begin
          state_next = fbba_pkg::ST_E_FULL;
        end
      end
      fbba_pkg::ST_A_OPEN: begin
        op         = fbba_pkg::OP_OPEN;
        state_next = fbba_pkg::ST_G_CALC;
      end
      fbba_pkg::ST_G_CALC: begin
        op         = fbba_pkg::OP_GCALC;
        state_next = fbba_pkg::ST_G_EMIT;
      end
      fbba_pkg::ST_G_EMIT: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_GRANT;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      fbba_pkg::ST_F_INIT: begin
        op         = fbba_pkg::OP_FINIT;
        state_next = fbba_pkg::ST_F_HEAD;
      end
      fbba_pkg::ST_F_HEAD: begin
        if (status.rem_zero) begin
          state_next = fbba_pkg::ST_U_INIT;
        end else begin
          op         = fbba_pkg::OP_QRD_FREE;
          state_next = fbba_pkg::ST_F_SLOT;
        end
      end
      fbba_pkg::ST_F_SLOT: begin
        op         = fbba_pkg::OP_SRD;
        state_next = fbba_pkg::ST_F_LAT;
      end
      fbba_pkg::ST_F_LAT: begin
        op         = fbba_pkg::OP_SLAT;
        state_next = fbba_pkg::ST_F_DEC;
      end
      fbba_pkg::ST_F_DEC: begin
        // A freed slot produces a result, so it waits for the output register.
        if (!status.f_release || status.out_free) begin
          op         = fbba_pkg::OP_FDEC;
          state_next = fbba_pkg::ST_F_HEAD;
        end
      end
      fbba_pkg::ST_U_INIT: begin
        op         = fbba_pkg::OP_UINIT;
        state_next = fbba_pkg::ST_U_HEAD;
      end
      fbba_pkg::ST_U_HEAD: begin
        if (status.rem_zero) begin
          if (status.type_last) begin
            state_next = fbba_pkg::ST_TB_DONE;
          end else begin
            op         = fbba_pkg::OP_NEXT_TYPE;
            state_next = fbba_pkg::ST_F_INIT;
          end
        end else begin
          op         = fbba_pkg::OP_QRD_USED;
          state_next = fbba_pkg::ST_U_SLOT;
        end
      end
      fbba_pkg::ST_U_SLOT: begin
        op         = fbba_pkg::OP_SRD;
        state_next = fbba_pkg::ST_U_LAT;
      end
      fbba_pkg::ST_U_LAT: begin
        op         = fbba_pkg::OP_SLAT;
        state_next = fbba_pkg::ST_U_DEC;
      end
      fbba_pkg::ST_U_DEC: begin
        if (status.u_held || !status.u_stale || status.out_free) begin
          op         = fbba_pkg::OP_UDEC;
          state_next = fbba_pkg::ST_U_HEAD;
        end
      end
      fbba_pkg::ST_TB_DONE: begin
        if (status.out_free) begin
          op         = fbba_pkg::OP_TB_DONE;
          state_next = fbba_pkg::ST_IDLE;
        end
      end
      default: state_next = fbba_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/fbba_datapath.sv
// Datapath of the bump allocator: configuration, slot table, per-type slot
// lists, byte averages and the output register. Depends on fbba_pkg, fbba_ram.
module fbba_datapath #(
  parameter int SLOTS_PER_TYPE = fbba_pkg::SLOTS_PER_TYPE_DEF,
  parameter int TYPE_COUNT     = fbba_pkg::TYPE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fbba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbba_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fbba_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [fbba_pkg::IN_USER_W-1:0]    s_tuser,
  input  fbba_pkg::op_t                     op,
  output fbba_pkg::dp_status_t              status,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [fbba_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [fbba_pkg::OUT_USER_W-1:0]   m_tuser,
  output logic                              m_tlast
);

  localparam int TOTAL = SLOTS_PER_TYPE * TYPE_COUNT;
  localparam int SW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
  localparam int PW    = SLOTS_PER_TYPE > 1 ? $clog2(SLOTS_PER_TYPE) : 1;
  localparam int CW    = $clog2(SLOTS_PER_TYPE + 1);
  localparam int TW    = TYPE_COUNT > 1 ? $clog2(TYPE_COUNT) : 1;
  localparam int QD    = 2 * TOTAL;
  localparam int QAW   = $clog2(QD);

  // Configuration registers.
  logic [7:0]  stale_age;
  logic [31:0] min_target, max_target;
  logic [4:0]  step_log2;

  // Allocator state.
  logic [TOTAL-1:0] in_use;
  logic [PW-1:0]    free_head [TYPE_COUNT];
  logic [PW-1:0]    used_head [TYPE_COUNT];
  logic [CW-1:0]    free_cnt  [TYPE_COUNT];
  logic [CW-1:0]    used_cnt  [TYPE_COUNT];
  logic [31:0]      tick_bytes [TYPE_COUNT];
  logic [31:0]      size_avg   [TYPE_COUNT];
  logic [31:0]      cur_tick;

  // Current request.
  fbba_pkg::cmd_t cmd;
  logic        item_type;
  logic [31:0] req_size, completed, start_tick;
  logic [4:0]  align_log2;

  // Working registers.
  logic [TW-1:0] t;
  logic [CW-1:0] rem;
  logic [SW-1:0] s;
  logic [31:0]   top, cap, last_tick, avgc, new_top, used_bytes, created;

  // Output register.
  fbba_pkg::event_t out_ev;
  logic [4:0]  out_slot;
  logic [31:0] out_off, out_gsz, out_csz;
  logic        out_last;

  // Memories.
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [SW-1:0]  q_wdata, q_rdata;
  logic           sl_we;
  logic [95:0]    sl_wdata, sl_rdata;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] h,
                                             input logic [CW-1:0] c);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(c);
    if (sum >= (CW+1)'(SLOTS_PER_TYPE)) sum = sum - (CW+1)'(SLOTS_PER_TYPE);
    return PW'(sum);
  endfunction

  // The free lists take the lower half of the list RAM, the used lists the upper.
  function automatic logic [QAW-1:0] qaddr(input logic used, input logic [TW-1:0] ty,
                                           input logic [PW-1:0] pos);
    return (used ? QAW'(TOTAL) : QAW'(0)) + QAW'(ty) * QAW'(SLOTS_PER_TYPE) + QAW'(pos);
  endfunction

  fbba_ram #(.WIDTH(SW), .DEPTH(QD)) u_list_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Slot table word: capacity, top, last tick from high to low.
  fbba_ram #(.WIDTH(96), .DEPTH(TOTAL)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(s), .wdata(sl_wdata),
    .raddr(q_rdata), .rdata(sl_rdata)
  );

  // Status toward the controller.
  logic          idle_found;
  logic [SW-1:0] idle_idx;
  logic          released, stale;

  always_comb begin
    logic [SW-1:0] cand;
    cand       = '0;
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = SLOTS_PER_TYPE - 1; i >= 0; i--) begin
      cand = SW'(int'(t) * SLOTS_PER_TYPE + i);
      if (!in_use[cand]) begin
        idle_found = 1'b1;
        idle_idx   = cand;
      end
    end
  end

  assign released = last_tick <= completed;
  assign stale    = ({1'b0, last_tick} + {25'd0, stale_age}) < {1'b0, start_tick};

  always_comb begin
    status.cmd        = cmd;
    status.size_zero  = req_size == 32'd0;
    status.type_bad   = int'(item_type) >= TYPE_COUNT;
    status.free_empty = free_cnt[t] == '0;
    status.rem_zero   = rem == '0;
    status.top_fits   = top >= req_size;
    status.idle_found = idle_found;
    status.f_release  = released && stale;
    status.u_held     = !released;
    status.u_stale    = stale;
    status.type_last  = t == TW'(TYPE_COUNT - 1);
    status.out_free   = !m_tvalid || m_tready;
  end

  // Arithmetic for opening a slot and for a grant.
  logic [31:0] avg_clamped, target, cap_value, mask, nt_value;
  logic [32:0] step, rounded, byte_sum;

  always_comb begin
    avg_clamped = size_avg[t];
    if (avg_clamped < min_target) avg_clamped = min_target;
    if (avg_clamped > max_target) avg_clamped = max_target;
    target    = (avgc > req_size) ? avgc : req_size;
    step      = 33'd1 << step_log2;
    rounded   = ({1'b0, target} + step - 33'd1) & ~(step - 33'd1);
    cap_value = rounded[32] ? 32'hFFFF_FFFF : rounded[31:0];
    mask      = 32'hFFFF_FFFF << align_log2;
    nt_value  = (top - req_size) & mask;
    byte_sum  = {1'b0, tick_bytes[t]} + {1'b0, used_bytes};
  end

  // List and slot table writes.
  always_comb begin
    q_we     = 1'b0;
    q_waddr  = qaddr(1'b0, t, wrap_add(free_head[t], free_cnt[t]));
    q_wdata  = s;
    sl_we    = 1'b0;
    sl_wdata = {cap, new_top, cur_tick};
    q_raddr  = (op == fbba_pkg::OP_QRD_USED) ? qaddr(1'b1, t, used_head[t])
                                             : qaddr(1'b0, t, free_head[t]);
    case (op)
      fbba_pkg::OP_MISS: begin
        q_we    = used_cnt[t] < CW'(SLOTS_PER_TYPE);
        q_waddr = qaddr(1'b1, t, wrap_add(used_head[t], used_cnt[t]));
      end
      fbba_pkg::OP_OPEN: begin
        q_we    = 1'b1;
        q_waddr = qaddr(1'b0, t, '0);
      end
      fbba_pkg::OP_FDEC: q_we = !(released && stale);
      fbba_pkg::OP_UDEC: begin
        if (!released) begin
          q_we    = 1'b1;
          q_waddr = qaddr(1'b1, t, wrap_add(used_head[t], used_cnt[t]));
        end else begin
          // Released by the finished tick: rewind the slot to its full capacity.
          sl_we    = 1'b1;
          sl_wdata = {cap, cap, last_tick};
          q_we     = !stale && (free_cnt[t] < CW'(SLOTS_PER_TYPE));
        end
      end
      fbba_pkg::OP_GRANT: sl_we = 1'b1;
      default: ;
    endcase
  end

  logic emit;
  always_comb begin
    case (op)
      fbba_pkg::OP_EMPTY, fbba_pkg::OP_FULL, fbba_pkg::OP_DONE, fbba_pkg::OP_TICK_END,
      fbba_pkg::OP_GRANT, fbba_pkg::OP_TB_DONE: emit = 1'b1;
      fbba_pkg::OP_FDEC: emit = released && stale;
      fbba_pkg::OP_UDEC: emit = released && stale;
      default:           emit = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_age  <= fbba_pkg::STALE_AGE_RST;
      min_target <= fbba_pkg::MIN_TARGET_RST;
      max_target <= fbba_pkg::MAX_TARGET_RST;
      step_log2  <= fbba_pkg::STEP_LOG2_RST;
      in_use     <= '0;
      cur_tick   <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
        free_head[i]  <= '0;
        used_head[i]  <= '0;
        free_cnt[i]   <= '0;
        used_cnt[i]   <= '0;
        tick_bytes[i] <= '0;
        size_avg[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (fbba_pkg::cfg_reg_t'(cfg_index))
          fbba_pkg::CFG_STALE_AGE:  stale_age  <= cfg_data[7:0];
          fbba_pkg::CFG_MIN_TARGET: min_target <= cfg_data;
          fbba_pkg::CFG_MAX_TARGET: max_target <= cfg_data;
          fbba_pkg::CFG_STEP_LOG2:  step_log2  <= cfg_data[4:0];
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (op)
        fbba_pkg::OP_MISS: begin
          free_head[t] <= wrap_add(free_head[t], CW'(1));
          free_cnt[t]  <= free_cnt[t] - CW'(1);
          if (used_cnt[t] < CW'(SLOTS_PER_TYPE)) used_cnt[t] <= used_cnt[t] + CW'(1);
        end
        fbba_pkg::OP_OPEN: begin
          in_use[s]    <= 1'b1;
          free_head[t] <= '0;
          free_cnt[t]  <= CW'(1);
        end
        fbba_pkg::OP_GRANT: begin
          tick_bytes[t] <= byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
        end
        fbba_pkg::OP_FDEC: begin
          free_head[t] <= wrap_add(free_head[t], CW'(1));
          if (released && stale) begin
            in_use[s]   <= 1'b0;
            free_cnt[t] <= free_cnt[t] - CW'(1);
          end
        end
        fbba_pkg::OP_UDEC: begin
          used_head[t] <= wrap_add(used_head[t], CW'(1));
          if (released) begin
            used_cnt[t] <= used_cnt[t] - CW'(1);
            if (stale) begin
              in_use[s] <= 1'b0;
            end else if (free_cnt[t] < CW'(SLOTS_PER_TYPE)) begin
              free_cnt[t] <= free_cnt[t] + CW'(1);
            end
          end
        end
        fbba_pkg::OP_TICK_END: begin
          for (int i = 0; i < TYPE_COUNT; i++) begin
            size_avg[i]   <= 32'(({1'b0, size_avg[i]} + {1'b0, tick_bytes[i]}) >> 1);
            tick_bytes[i] <= '0;
          end
        end
        fbba_pkg::OP_TB_DONE: cur_tick <= start_tick;
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    case (op)
      fbba_pkg::OP_LATCH: begin
        cmd        <= fbba_pkg::cmd_t'(s_tuser[1:0]);
        item_type  <= s_tuser[2];
        t          <= TW'(s_tuser[2]);
        req_size   <= s_tdata[31:0];
        align_log2 <= s_tdata[36:32];
        completed  <= s_tdata[68:37];
        start_tick <= s_tdata[100:69];
        created    <= '0;
      end
      fbba_pkg::OP_TB_START:  t <= '0;
      fbba_pkg::OP_NEXT_TYPE: t <= t + TW'(1);
      fbba_pkg::OP_SRD:       s <= q_rdata;
      fbba_pkg::OP_SLAT:      {cap, top, last_tick} <= sl_rdata;
      fbba_pkg::OP_FIND: begin
        s    <= idle_idx;
        avgc <= avg_clamped;
      end
      fbba_pkg::OP_OPEN: begin
        cap     <= cap_value;
        top     <= cap_value;
        created <= cap_value;
      end
      fbba_pkg::OP_GCALC: begin
        new_top    <= nt_value;
        used_bytes <= top - nt_value;
      end
      fbba_pkg::OP_FINIT: rem <= free_cnt[t];
      fbba_pkg::OP_UINIT: rem <= used_cnt[t];
      fbba_pkg::OP_FDEC, fbba_pkg::OP_UDEC: rem <= rem - CW'(1);
      default: ;
    endcase

    if (emit) begin
      out_slot <= '0;
      out_off  <= '0;
      out_gsz  <= '0;
      out_csz  <= '0;
      out_last <= 1'b1;
      case (op)
        fbba_pkg::OP_EMPTY: out_ev <= fbba_pkg::EV_EMPTY;
        fbba_pkg::OP_FULL:  out_ev <= fbba_pkg::EV_FULL;
        fbba_pkg::OP_GRANT: begin
          out_ev   <= fbba_pkg::EV_GRANT;
          out_slot <= 5'(s);
          out_off  <= new_top;
          out_gsz  <= used_bytes;
          out_csz  <= created;
        end
        fbba_pkg::OP_FDEC, fbba_pkg::OP_UDEC: begin
          out_ev   <= fbba_pkg::EV_FREED;
          out_slot <= 5'(s);
          out_last <= 1'b0;
        end
        default: out_ev <= fbba_pkg::EV_DONE;
      endcase
    end
  end

  assign m_tdata = {3'd0, out_csz, out_gsz, out_off, out_slot};
  assign m_tuser = out_ev;
  assign m_tlast = out_last;

endmodule
